// ----- src/caac_pkg.sv -----
// ----------------------------------------------------------------------------
// caac_pkg: shared types and constants of the circular arc angle clamp
// Field types, request and result structs, and the wrap constants.
// ----------------------------------------------------------------------------
package caac_pkg;

    typedef logic [11:0]        angle_t;
    typedef logic [9:0]         margin_t;
    typedef logic signed [13:0] arith_t;

    typedef struct packed {
        angle_t  angle;
        angle_t  arc_start;
        angle_t  arc_end;
        margin_t margin;
    } query_t;

    typedef struct packed {
        logic   inside_res;
        angle_t adjusted_angle;
    } result_t;

    // Inside test wraps by a full turn; clamp and midpoint wrap by one less.
    localparam arith_t WRAP_FULL  = 14'sd4096;
    localparam arith_t WRAP_CLAMP = 14'sd4095;
    localparam arith_t DIST_FOLD  = 14'sd2049;
    localparam arith_t DIST_REF   = 14'sd4095;

    function automatic arith_t to_arith(input angle_t x);
        to_arith = $signed({2'b00, x});
    endfunction

endpackage

// ----- src/caac_query_if.sv -----
// ----------------------------------------------------------------------------
// caac_query_if: request channel of the arc clamp
// Valid/ready handshake carrying the angle and the arc description.
// ----------------------------------------------------------------------------
interface caac_query_if import caac_pkg::*; ();
    logic    valid;
    logic    ready;
    angle_t  angle;
    angle_t  arc_start;
    angle_t  arc_end;
    margin_t margin;

    modport source (output valid, output angle, output arc_start, output arc_end,
                    output margin, input ready);
    modport sink   (input valid, input angle, input arc_start, input arc_end,
                    input margin, output ready);
endinterface

// ----- src/caac_result_if.sv -----
// ----------------------------------------------------------------------------
// caac_result_if: result channel of the arc clamp
// Valid/ready handshake carrying the inside flag and the adjusted angle.
// ----------------------------------------------------------------------------
interface caac_result_if import caac_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   inside_res;
    angle_t adjusted_angle;

    modport source (output valid, output inside_res, output adjusted_angle,
                    input ready);
    modport sink   (input valid, input inside_res, input adjusted_angle,
                    output ready);
endinterface

// ----- src/circular_arc_angle_clamp.sv -----
// ----------------------------------------------------------------------------
// circular_arc_angle_clamp: angle test and clamp against a circular arc
// Input register, single combinational pass, result register.
// ----------------------------------------------------------------------------
// Path: input register, combinational logic, result register. Throughput:
// one request per cycle unless the output stalls; the input and result
// registers form a two-entry pipeline, so a request is taken while a result
// waits if the input register is empty.
// Reset: rst_n clears both valid flags; payload registers are not reset.
module circular_arc_angle_clamp
    import caac_pkg::*;
#(
    parameter int CLAMP_INSET = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    caac_query_if.sink    query,
    caac_result_if.source result
);

    query_t  query_reg;
    logic    query_valid_reg;
    result_t result_reg, result_next;
    logic    result_valid_reg;
    logic    advance;
    logic    in_arc;
    angle_t  clamped;

    assign advance     = !result_valid_reg || result.ready;
    assign query.ready = !query_valid_reg || advance;

    caac_inside_test u_inside
    (
        .q      (query_reg),
        .in_arc (in_arc)
    );

    caac_clamp #(.CLAMP_INSET(CLAMP_INSET)) u_clamp
    (
        .q       (query_reg),
        .clamped (clamped)
    );

    always_comb
    begin
        result_next.inside_res     = in_arc;
        result_next.adjusted_angle = in_arc ? query_reg.angle : clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (query.ready)
                query_valid_reg <= query.valid;
            if (advance)
                result_valid_reg <= query_valid_reg;
        end
    end

    // hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (query.valid && query.ready)
        begin
            query_reg.angle     <= query.angle;
            query_reg.arc_start <= query.arc_start;
            query_reg.arc_end   <= query.arc_end;
            query_reg.margin    <= query.margin;
        end
        if (advance && query_valid_reg)
            result_reg <= result_next;
    end

    assign result.valid          = result_valid_reg;
    assign result.inside_res     = result_reg.inside_res;
    assign result.adjusted_angle = result_reg.adjusted_angle;

endmodule

// ----- src/caac_inside_test.sv -----
// ----------------------------------------------------------------------------
// caac_inside_test: inside test against the arc shrunk by the margin
// Handles plain arcs and the four wrap cases of arcs that run past zero.
// ----------------------------------------------------------------------------
module caac_inside_test
    import caac_pkg::*;
(
    input  query_t q,
    output logic   in_arc
);

    arith_t a, s, e, lo, hi, lo_w, hi_w;
    logic   lo_wraps, hi_wraps;

    always_comb
    begin
        a  = to_arith(q.angle);
        s  = to_arith(q.arc_start);
        e  = to_arith(q.arc_end);
        lo = s + $signed({4'b0000, q.margin});
        hi = e - $signed({4'b0000, q.margin});
        lo_wraps = (lo >= WRAP_FULL);
        hi_wraps = (hi < 14'sd0);
        lo_w = lo_wraps ? lo - WRAP_FULL : lo;
        hi_w = hi_wraps ? hi + WRAP_FULL : hi;

        priority if (e >= s)
        begin
            in_arc = (lo < hi) && (a >= lo) && (hi >= a);
        end
        else if (!lo_wraps && !hi_wraps)
        begin
            in_arc = (a >= lo_w) || (hi_w >= a);
        end
        else if (lo_wraps && hi_wraps)
        begin
            in_arc = 1'b0;
        end
        else
        begin
            in_arc = (lo_w < hi_w) && (a >= lo_w) && (hi_w >= a);
        end
    end

endmodule

// ----- src/caac_clamp.sv -----
// ----------------------------------------------------------------------------
// caac_clamp: clamp of an outside angle toward the nearer arc end
// Picks the nearer end by circular distance, steps inward, falls back to
// the arc midpoint when the stepped point leaves the arc.
// ----------------------------------------------------------------------------
module caac_clamp
    import caac_pkg::*;
#(
    parameter int CLAMP_INSET = 10
)
(
    input  query_t q,
    output angle_t clamped
);

    localparam arith_t INSET = $signed({4'b0000, 10'(CLAMP_INSET)});

    function automatic arith_t circ_dist(input arith_t x, input arith_t y);
        arith_t d;
        d = x - y;
        if (d < 14'sd0)
            d = -d;
        if (d >= DIST_FOLD)
            d = DIST_REF - d;
        circ_dist = d;
    endfunction

    arith_t a, s, e, lo, hi, v, mid, span, t;
    logic   leaves_arc;

    always_comb
    begin
        a  = to_arith(q.angle);
        s  = to_arith(q.arc_start);
        e  = to_arith(q.arc_end);
        lo = s + INSET;
        hi = e - INSET;
        if (lo >= WRAP_FULL)
            lo = lo - WRAP_CLAMP;
        if (hi < 14'sd0)
            hi = hi + WRAP_CLAMP;
        // ties go to the start end
        v = (circ_dist(e, a) >= circ_dist(s, a)) ? lo : hi;

        span = (e - s) + WRAP_CLAMP;
        t    = (span >>> 1) + s;
        if (t >= WRAP_FULL)
            t = t - WRAP_CLAMP;
        mid = (e >= s) ? ((s + e) >>> 1) : t;

        if (e >= s)
            leaves_arc = (v < s) || (e < v);
        else
            leaves_arc = (v < s) && (e < v);

        clamped = leaves_arc ? mid[11:0] : v[11:0];
    end

endmodule

// ----- src/caac_checker.sv -----
// ----------------------------------------------------------------------------
// caac_checker: port-level checks of the arc clamp
// Backpressure, pipeline delivery and result hold under stall.
// ----------------------------------------------------------------------------
module caac_checker
    import caac_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input logic   out_inside,
    input angle_t out_angle
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_inside)
                                    && $stable(out_angle))
        else $error("result changed while stalled");

    // requests are refused only when both stages are full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request refused with room in the pipeline");

    // an accepted request shows up at the output after the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("accepted request produced no result");

endmodule

bind circular_arc_angle_clamp caac_checker u_caac_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_inside (result.inside_res),
    .out_angle  (result.adjusted_angle)
);
